>>> design/rtb_pkg.sv
`default_nettype none
package rtb_pkg;
  localparam int TableDepth = 64;
  localparam int TagWidth = 32;
  localparam int PayloadWidth = 32;
  localparam logic [7:0] RetryResetLimit = 8'd5;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_ERASE  = 3'd1,
    KIND_LOOKUP = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_BEGIN  = 3'd4,
    KIND_PEEK   = 3'd5,
    KIND_MARK   = 3'd6,
    KIND_NONE   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    CFG_DC_LIMIT  = 2'd0,
    CFG_NDC_LIMIT = 2'd1,
    CFG_DC_COMPAT = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WAIT,
    ST_EVAL,
    ST_MOVE_RD,
    ST_MOVE_WAIT,
    ST_MOVE_WR,
    ST_PEEK_WAIT,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

>>> design/retransmission_table_burst.sv
`default_nettype none
// Keyed retransmission table. Entries (tag, payload, retry count) live packed in
// one synchronous RAM; add, erase, lookup and mark_sent search it linearly, slot
// by slot (each slot is read, then compared), and an erase or eviction then moves
// the last entry into the hole.
// One item is in work at a time; the result sits in an output register and the
// next item is taken once it has left.
module retransmission_table_burst #(
  parameter int TABLE_DEPTH   = rtb_pkg::TableDepth,
  parameter int TAG_WIDTH     = rtb_pkg::TagWidth,
  parameter int PAYLOAD_WIDTH = rtb_pkg::PayloadWidth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // kind[2:0], lookup_tag, payload (zero padded to bytes)
  input  wire logic [((3+TAG_WIDTH+PAYLOAD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // hit, inserted, table_full, payload_out, payload_valid, evicted,
  // occupancy, burst_pending, list_nonempty (zero padded to bytes)
  output logic [((5+PAYLOAD_WIDTH+$clog2(TABLE_DEPTH+1)+2+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import rtb_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = TAG_WIDTH + PAYLOAD_WIDTH + 8;
  localparam int OW = 5 + PAYLOAD_WIDTH + CW + 2;
  localparam int OBW = ((OW + 7) / 8) * 8;

  logic [7:0] dc_limit, ndc_limit;
  logic       dc_compat;

  state_t state, state_next;
  kind_t  kind;
  logic [TAG_WIDTH-1:0]     tag;
  logic [PAYLOAD_WIDTH-1:0] pay;
  logic [CW-1:0] count, ptr_cnt, burst, scan, slot;
  logic          hit, inserted, full, pvalid, evicted;
  logic [PAYLOAD_WIDTH-1:0] pout;
  logic          out_valid;
  logic [OW-1:0] out_word;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [TAG_WIDTH-1:0]     r_tag;
  logic [PAYLOAD_WIDTH-1:0] r_pay;
  logic [7:0]               r_retry;

  rtb_ram #(.Width(EW), .Depth(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign r_tag   = rdata[TAG_WIDTH-1:0];
  assign r_pay   = rdata[TAG_WIDTH +: PAYLOAD_WIDTH];
  assign r_retry = rdata[EW-1 -: 8];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_limit  <= RetryResetLimit;
      ndc_limit <= RetryResetLimit;
      dc_compat <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DC_LIMIT:  dc_limit  <= cfg_data;
        CFG_NDC_LIMIT: ndc_limit <= cfg_data;
        CFG_DC_COMPAT: dc_compat <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OBW-OW){1'b0}}, out_word};

  logic [7:0] limit, retry_inc;
  logic       match, scan_end, evict;
  assign limit     = dc_compat ? dc_limit : ndc_limit;
  assign retry_inc = (r_retry == 8'hFF) ? r_retry : r_retry + 8'd1;
  assign match     = (r_tag == tag);
  assign scan_end  = (scan + CW'(1) >= count);
  assign evict     = (retry_inc >= limit);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          case (kind_t'(s_axis_tdata[2:0]))
            KIND_ADD, KIND_ERASE, KIND_LOOKUP, KIND_MARK: state_next = ST_SEARCH;
            KIND_PEEK: state_next = ST_PEEK_WAIT;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SEARCH:  state_next = (count == '0) ? ST_EVAL : ST_WAIT;
      ST_WAIT:    state_next = ST_EVAL;
      ST_EVAL: begin
        if (hit || count == '0 || !match && scan_end) state_next = ST_DONE;
        else if (match) begin
          if (kind == KIND_ERASE || (kind == KIND_MARK && evict)) state_next = ST_MOVE_RD;
          else state_next = ST_DONE;
        end else state_next = ST_WAIT;
      end
      ST_MOVE_RD:   state_next = ST_MOVE_WAIT;
      ST_MOVE_WAIT: state_next = ST_MOVE_WR;
      ST_MOVE_WR:   state_next = ST_DONE;
      ST_PEEK_WAIT: state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // memory port
  always_comb begin
    we = 1'b0;
    waddr = slot[AW-1:0];
    wdata = {r_retry, pay, tag};
    raddr = scan[AW-1:0];
    case (state)
      // send pointer slot, ready for a peek
      ST_IDLE:   raddr = (ptr_cnt >= count) ? '0 : ptr_cnt[AW-1:0];
      ST_SEARCH: raddr = '0;
      ST_WAIT:   raddr = scan[AW-1:0];
      ST_EVAL: begin
        raddr = scan[AW-1:0] + AW'(1);
        if (match && count != '0 && !hit) begin
          if (kind == KIND_ADD) begin
            we = 1'b1; waddr = scan[AW-1:0]; wdata = {r_retry, pay, r_tag};
          end else if (kind == KIND_MARK && !evict) begin
            we = 1'b1; waddr = scan[AW-1:0]; wdata = {retry_inc, r_pay, r_tag};
          end
        end else if (kind == KIND_ADD && !hit && (count == '0 || scan_end)
                     && count < CW'(TABLE_DEPTH)) begin
          we = 1'b1; waddr = count[AW-1:0]; wdata = {8'd0, pay, tag};
        end
      end
      ST_MOVE_RD, ST_MOVE_WAIT: raddr = AW'(count - CW'(1));
      ST_MOVE_WR: begin
        we = (slot != count - CW'(1)); waddr = slot[AW-1:0]; wdata = rdata;
      end
      ST_PEEK_WAIT: raddr = ptr_cnt[AW-1:0];
      default: ;
    endcase
  end

  logic [CW-1:0] cnt_m1;
  assign cnt_m1 = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0; ptr_cnt <= '0; burst <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          kind <= kind_t'(s_axis_tdata[2:0]);
          tag  <= s_axis_tdata[3 +: TAG_WIDTH];
          pay  <= s_axis_tdata[3+TAG_WIDTH +: PAYLOAD_WIDTH];
          hit <= 1'b0; inserted <= 1'b0; full <= 1'b0;
          pvalid <= 1'b0; evicted <= 1'b0; pout <= '0;
          scan <= '0;
          if (kind_t'(s_axis_tdata[2:0]) == KIND_PEEK) begin
            if (ptr_cnt >= count) ptr_cnt <= '0;
          end
        end
        ST_EVAL: begin
          if (!hit) begin
            if (count != '0 && match) begin
              hit <= 1'b1; slot <= scan;
              case (kind)
                KIND_LOOKUP: begin pout <= r_pay; pvalid <= 1'b1; end
                KIND_MARK: if (evict) evicted <= 1'b1;
                  else begin
                    ptr_cnt <= (ptr_cnt + CW'(1) >= count) ? '0 : ptr_cnt + CW'(1);
                    if (burst != '0) burst <= burst - CW'(1);
                  end
                default: ;
              endcase
            end else if (count == '0 || scan_end) begin
              if (kind == KIND_ADD) begin
                if (count < CW'(TABLE_DEPTH)) begin
                  count <= count + CW'(1); inserted <= 1'b1;
                end else full <= 1'b1;
              end
            end else scan <= scan + CW'(1);
          end
        end
        ST_MOVE_WR: begin
          count <= cnt_m1;
          if (cnt_m1 == '0) begin
            ptr_cnt <= '0; burst <= '0;
          end else begin
            if (ptr_cnt >= cnt_m1) ptr_cnt <= '0;
            if (burst != '0) burst <= burst - CW'(1);
          end
        end
        ST_PEEK_WAIT: begin
          if (burst != '0 && count != '0) begin
            pout <= r_pay; pvalid <= 1'b1;
          end
        end
        ST_DONE: begin
          case (kind)
            KIND_CLEAR: begin count <= '0; ptr_cnt <= '0; burst <= '0; end
            KIND_BEGIN: begin
              burst <= count;
              if (ptr_cnt >= count) ptr_cnt <= '0;
            end
            default: ;
          endcase
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic [CW-1:0] occ_f, burst_f;
  assign occ_f   = (kind == KIND_CLEAR) ? '0 : count;
  assign burst_f = (kind == KIND_CLEAR) ? '0 : (kind == KIND_BEGIN) ? count : burst;

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      out_word <= {occ_f != '0, burst_f != '0, occ_f, evicted, pvalid, pout,
                   full, inserted, hit};
    end
  end
endmodule
`default_nettype wire

>>> design/rtb_ram.sv
`default_nettype none
module rtb_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
